// ===== sv/hcb_pkg.sv =====
package hcb_pkg;

    localparam int LETTER_W = 5;
    localparam int ID_W     = 6;
    localparam int CODE_W   = 25;
    localparam int LEN_W    = 5;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    typedef enum logic [1:0] {
        FUNC_COUNT  = 2'd0,
        FUNC_FINISH = 2'd1,
        FUNC_ENCODE = 2'd2,
        FUNC_CLEAR  = 2'd3
    } t_func;

    // letter cell commands
    typedef enum logic [2:0] {
        LC_IDLE,
        LC_COUNT,
        LC_CLEAR,
        LC_INIT,
        LC_MERGE,
        LC_LONE
    } t_lc_cmd;

    typedef struct packed {
        t_lc_cmd             cmd;
        logic [LETTER_W-1:0] idx;
        logic [ID_W-1:0]     id_a;
        logic [ID_W-1:0]     id_b;
        logic [ID_W-1:0]     id_new;
    } t_lc_op;

    // queue cell commands
    typedef enum logic [1:0] {
        QC_HOLD,
        QC_INSERT,
        QC_POP2,
        QC_CLEAR
    } t_qc_cmd;

    // {is_letter, index} for a raw byte, case folded
    function automatic logic [LETTER_W:0] letter_of(input logic [7:0] c);
        logic [7:0] d;
        logic       ok;
        d  = 8'd0;
        ok = 1'b0;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            d  = c - CH_UPPER_A;
            ok = 1'b1;
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            d  = c - CH_LOWER_A;
            ok = 1'b1;
        end
        return {ok, d[LETTER_W-1:0]};
    endfunction

endpackage

// ===== sv/hcb_letter_cell.sv =====
module hcb_letter_cell #(
    parameter int INDEX       = 0,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  hcb_pkg::t_lc_op            i_op,
    output logic [COUNT_WIDTH-1:0]     o_count,
    output logic [hcb_pkg::CODE_W-1:0] o_code,
    output logic [hcb_pkg::LEN_W-1:0]  o_len
);

    localparam logic [hcb_pkg::LETTER_W-1:0] MY_IDX = hcb_pkg::LETTER_W'(INDEX);
    localparam logic [hcb_pkg::ID_W-1:0]     MY_ID  = hcb_pkg::ID_W'(INDEX);

    logic [COUNT_WIDTH-1:0]     r_count;
    logic [hcb_pkg::ID_W-1:0]   r_owner;
    logic [hcb_pkg::CODE_W-1:0] r_code;
    logic [hcb_pkg::LEN_W-1:0]  r_len;
    logic [hcb_pkg::CODE_W-1:0] one_bit;

    // merge prepends a bit above the current code
    assign one_bit = hcb_pkg::CODE_W'(1) << r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_owner <= MY_ID;
            r_code  <= '0;
            r_len   <= '0;
        end else begin
            case (i_op.cmd)
                hcb_pkg::LC_COUNT: begin
                    if (i_op.idx == MY_IDX && r_count != {COUNT_WIDTH{1'b1}}) begin
                        r_count <= r_count + COUNT_WIDTH'(1);
                    end
                end
                hcb_pkg::LC_CLEAR: begin
                    r_count <= '0;
                    r_owner <= MY_ID;
                    r_code  <= '0;
                    r_len   <= '0;
                end
                hcb_pkg::LC_INIT: begin
                    r_owner <= MY_ID;
                    r_code  <= '0;
                    r_len   <= '0;
                end
                hcb_pkg::LC_MERGE: begin
                    if (r_owner == i_op.id_a) begin
                        r_len   <= r_len + hcb_pkg::LEN_W'(1);
                        r_owner <= i_op.id_new;
                    end else if (r_owner == i_op.id_b) begin
                        r_code  <= r_code | one_bit;
                        r_len   <= r_len + hcb_pkg::LEN_W'(1);
                        r_owner <= i_op.id_new;
                    end
                end
                hcb_pkg::LC_LONE: begin
                    if (i_op.idx == MY_IDX) begin
                        r_code <= hcb_pkg::CODE_W'(1);
                        r_len  <= hcb_pkg::LEN_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_count = r_count;
    assign o_code  = r_code;
    assign o_len   = r_len;

endmodule

// ===== sv/hcb_queue_cell.sv =====
module hcb_queue_cell #(
    parameter int WEIGHT_W = 21
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  hcb_pkg::t_qc_cmd         i_cmd,
    input  logic [WEIGHT_W-1:0]      i_new_w,
    input  logic [hcb_pkg::ID_W-1:0] i_new_id,
    input  logic [WEIGHT_W-1:0]      i_prev_w,
    input  logic [hcb_pkg::ID_W-1:0] i_prev_id,
    input  logic                     i_prev_valid,
    input  logic                     i_prev_keep,
    input  logic [WEIGHT_W-1:0]      i_skip_w,
    input  logic [hcb_pkg::ID_W-1:0] i_skip_id,
    input  logic                     i_skip_valid,
    output logic [WEIGHT_W-1:0]      o_w,
    output logic [hcb_pkg::ID_W-1:0] o_id,
    output logic                     o_valid,
    output logic                     o_keep
);

    logic [WEIGHT_W-1:0]      r_w;
    logic [hcb_pkg::ID_W-1:0] r_id;
    logic                     r_valid;

    // entries of equal or smaller weight stay ahead of the new one
    assign o_keep = r_valid && (r_w <= i_new_w);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            case (i_cmd)
                hcb_pkg::QC_INSERT: begin
                    if (!o_keep) begin
                        if (i_prev_keep) begin
                            r_w     <= i_new_w;
                            r_id    <= i_new_id;
                            r_valid <= 1'b1;
                        end else begin
                            r_w     <= i_prev_w;
                            r_id    <= i_prev_id;
                            r_valid <= i_prev_valid;
                        end
                    end
                end
                hcb_pkg::QC_POP2: begin
                    r_w     <= i_skip_w;
                    r_id    <= i_skip_id;
                    r_valid <= i_skip_valid;
                end
                hcb_pkg::QC_CLEAR: begin
                    r_valid <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_w     = r_w;
    assign o_id    = r_id;
    assign o_valid = r_valid;

endmodule

// ===== sv/letter_huffman_code_builder_core.sv =====
// letter huffman code builder: a count request (tuser 0) adds the letter in
// tdata to a saturating counter, case folded, other bytes ignored; a finish
// request (tuser 1) builds the huffman tree over the letters present and
// sends one result per present letter in letter order, tlast on the final
// one (or a single result with tuser set when no letter was counted); an
// encode request (tuser 2) returns the stored code of one letter; a clear
// request (tuser 3) returns everything to reset. finish loads the sorted
// merge queue by scanning every letter, then runs n - 1 merges for n
// present letters, each a double pop followed by a sorted insert, then
// scans out the table over every letter, holding on any output stall. the
// queue is a chain of cells that takes one sorted insert or one double pop
// per cycle. codes build bottom up: each merge prepends a bit in every
// letter cell of the two merged subtrees.
module letter_huffman_code_builder_core #(
    parameter int ALPHABET    = 26,
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,  // [7:0] char_code
    input  logic [1:0]  i_s_tuser,  // [1:0] func
    // result side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,  // [4:0] letter, [29:5] code_word, [34:30] code_len
    output logic        o_m_tuser,  // [0] no_symbols
    output logic        o_m_tlast
);

    localparam int IDX_W    = $clog2(ALPHABET);
    localparam int QN_W     = $clog2(ALPHABET + 1);
    localparam int WEIGHT_W = COUNT_WIDTH + 5;
    localparam int LW       = hcb_pkg::LETTER_W;
    localparam int CW       = hcb_pkg::CODE_W;
    localparam int NW       = hcb_pkg::LEN_W;
    localparam int IW       = hcb_pkg::ID_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_LONE,
        S_POP,
        S_INS,
        S_EMIT,
        S_NONE,
        S_ENC
    } t_state;

    t_state             r_state;
    logic [QN_W-1:0]    r_qn;
    logic [IW-1:0]      r_next;
    logic [IDX_W-1:0]   r_scan;
    logic [IDX_W-1:0]   r_idx;
    logic               r_idx_ok;
    logic [WEIGHT_W-1:0] r_w;
    logic               r_m_valid;
    logic [39:0]        r_m_data;
    logic               r_m_user;
    logic               r_m_last;

    // letter cells
    hcb_pkg::t_lc_op        lc_op;
    logic [COUNT_WIDTH-1:0] lc_count [ALPHABET];
    logic [CW-1:0]          lc_code  [ALPHABET];
    logic [NW-1:0]          lc_len   [ALPHABET];
    logic [ALPHABET-1:0]    present;

    // merge queue cells
    hcb_pkg::t_qc_cmd    qc_cmd;
    logic [WEIGHT_W-1:0] qc_new_w;
    logic [IW-1:0]       qc_new_id;
    logic [WEIGHT_W-1:0] q_w     [ALPHABET];
    logic [IW-1:0]       q_id    [ALPHABET];
    logic                q_valid [ALPHABET];
    logic                q_keep  [ALPHABET];

    logic                 in_fire;
    logic                 slot_free;
    logic                 out_load;
    hcb_pkg::t_func       in_func;
    logic [LW:0]          in_letter;
    logic                 in_ok;
    logic [IDX_W-1:0]     rd_idx;
    logic                 scan_last;
    logic [ALPHABET-1:0]  present_hi;
    logic [QN_W-1:0]      load_total;

    assign in_func   = hcb_pkg::t_func'(i_s_tuser);
    assign in_letter = hcb_pkg::letter_of(i_s_tdata);
    // letters past the alphabet count as non-letters
    assign in_ok     = in_letter[LW] && (32'(in_letter[LW-1:0]) < ALPHABET);
    assign o_s_tready = (r_state == S_IDLE);
    assign in_fire   = i_s_tvalid && o_s_tready;
    assign slot_free = !r_m_valid || i_m_tready;

    // a new result enters the output register this cycle
    assign out_load = slot_free && ((r_state == S_EMIT && present[r_scan])
                                    || r_state == S_NONE || r_state == S_ENC);

    genvar gi;
    generate
        for (gi = 0; gi < ALPHABET; gi++) begin : g_cell
            hcb_letter_cell #(
                .INDEX       (gi),
                .COUNT_WIDTH (COUNT_WIDTH)
            ) u_letter (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_op    (lc_op),
                .o_count (lc_count[gi]),
                .o_code  (lc_code[gi]),
                .o_len   (lc_len[gi])
            );
            assign present[gi] = (lc_count[gi] != '0);

            logic [WEIGHT_W-1:0] prev_w;
            logic [IW-1:0]       prev_id;
            logic                prev_valid;
            logic                prev_keep;
            logic [WEIGHT_W-1:0] skip_w;
            logic [IW-1:0]       skip_id;
            logic                skip_valid;

            if (gi == 0) begin : g_head
                assign prev_w     = '0;
                assign prev_id    = '0;
                assign prev_valid = 1'b0;
                assign prev_keep  = 1'b1;
            end else begin : g_body
                assign prev_w     = q_w[gi-1];
                assign prev_id    = q_id[gi-1];
                assign prev_valid = q_valid[gi-1];
                assign prev_keep  = q_keep[gi-1];
            end

            if (gi + 2 < ALPHABET) begin : g_skip
                assign skip_w     = q_w[gi+2];
                assign skip_id    = q_id[gi+2];
                assign skip_valid = q_valid[gi+2];
            end else begin : g_tail
                assign skip_w     = '0;
                assign skip_id    = '0;
                assign skip_valid = 1'b0;
            end

            hcb_queue_cell #(
                .WEIGHT_W (WEIGHT_W)
            ) u_queue (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_cmd        (qc_cmd),
                .i_new_w      (qc_new_w),
                .i_new_id     (qc_new_id),
                .i_prev_w     (prev_w),
                .i_prev_id    (prev_id),
                .i_prev_valid (prev_valid),
                .i_prev_keep  (prev_keep),
                .i_skip_w     (skip_w),
                .i_skip_id    (skip_id),
                .i_skip_valid (skip_valid),
                .o_w          (q_w[gi]),
                .o_id         (q_id[gi]),
                .o_valid      (q_valid[gi]),
                .o_keep       (q_keep[gi])
            );
        end
    endgenerate

    // one read port on the letter cells
    assign rd_idx = (r_state == S_EMIT) ? r_scan : r_idx;

    // final result of a table when no present letter lies above the scan point
    assign present_hi = present >> r_scan;
    assign scan_last  = (present_hi[ALPHABET-1:1] == '0);
    assign load_total = r_qn + QN_W'(present[r_scan]);

    // cell commands
    always_comb begin
        lc_op        = '0;
        lc_op.cmd    = hcb_pkg::LC_IDLE;
        qc_cmd       = hcb_pkg::QC_HOLD;
        qc_new_w     = r_w;
        qc_new_id    = r_next;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (in_func)
                        hcb_pkg::FUNC_COUNT: begin
                            if (in_ok) begin
                                lc_op.cmd = hcb_pkg::LC_COUNT;
                                lc_op.idx = in_letter[LW-1:0];
                            end
                        end
                        hcb_pkg::FUNC_FINISH: begin
                            lc_op.cmd = hcb_pkg::LC_INIT;
                            qc_cmd    = hcb_pkg::QC_CLEAR;
                        end
                        hcb_pkg::FUNC_CLEAR: begin
                            lc_op.cmd = hcb_pkg::LC_CLEAR;
                            qc_cmd    = hcb_pkg::QC_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LOAD: begin
                qc_new_w  = WEIGHT_W'(lc_count[r_scan]);
                qc_new_id = IW'(r_scan);
                if (present[r_scan]) begin
                    qc_cmd = hcb_pkg::QC_INSERT;
                end
            end
            S_LONE: begin
                lc_op.cmd = hcb_pkg::LC_LONE;
                lc_op.idx = q_id[0][LW-1:0];
            end
            S_POP: begin
                lc_op.cmd    = hcb_pkg::LC_MERGE;
                lc_op.id_a   = q_id[0];
                lc_op.id_b   = q_id[1];
                lc_op.id_new = r_next;
                qc_cmd       = hcb_pkg::QC_POP2;
            end
            S_INS: begin
                qc_cmd = hcb_pkg::QC_INSERT;
            end
            default: begin
            end
        endcase
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_qn      <= '0;
            r_next    <= '0;
            r_scan    <= '0;
            r_idx     <= '0;
            r_idx_ok  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        case (in_func)
                            hcb_pkg::FUNC_FINISH: begin
                                r_qn    <= '0;
                                r_scan  <= '0;
                                r_state <= S_LOAD;
                            end
                            hcb_pkg::FUNC_ENCODE: begin
                                r_idx    <= in_letter[IDX_W-1:0];
                                r_idx_ok <= in_ok;
                                r_state  <= S_ENC;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_LOAD: begin
                    r_qn <= load_total;
                    if (r_scan == IDX_W'(ALPHABET - 1)) begin
                        r_scan <= '0;
                        r_next <= IW'(ALPHABET);
                        if (load_total == '0) begin
                            r_state <= S_NONE;
                        end else if (load_total == QN_W'(1)) begin
                            r_state <= S_LONE;
                        end else begin
                            r_state <= S_POP;
                        end
                    end else begin
                        r_scan <= r_scan + IDX_W'(1);
                    end
                end
                S_LONE: begin
                    r_state <= S_EMIT;
                end
                S_POP: begin
                    r_w     <= q_w[0] + q_w[1];
                    r_qn    <= r_qn - QN_W'(2);
                    r_state <= S_INS;
                end
                S_INS: begin
                    r_qn   <= r_qn + QN_W'(1);
                    r_next <= r_next + IW'(1);
                    if (r_qn == '0) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_POP;
                    end
                end
                S_EMIT: begin
                    if (!present[r_scan] || slot_free) begin
                        if (present[r_scan]) begin
                            r_m_data  <= {5'd0, lc_len[rd_idx], lc_code[rd_idx],
                                          LW'(r_scan)};
                            r_m_user  <= 1'b0;
                            r_m_last  <= scan_last;
                        end
                        if (r_scan == IDX_W'(ALPHABET - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_scan <= r_scan + IDX_W'(1);
                        end
                    end
                end
                S_NONE: begin
                    if (slot_free) begin
                        r_m_data  <= '0;
                        r_m_user  <= 1'b1;
                        r_m_last  <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                S_ENC: begin
                    if (slot_free) begin
                        if (r_idx_ok) begin
                            r_m_data <= {5'd0, lc_len[rd_idx], lc_code[rd_idx],
                                         LW'(r_idx)};
                        end else begin
                            r_m_data <= '0;
                        end
                        r_m_user <= 1'b0;
                        r_m_last <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;
    assign o_m_tlast  = r_m_last;

    // queue front stays sorted
    a_front_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_valid[1] |-> (q_valid[0] && q_w[0] <= q_w[1]))
        else $error("merge queue front out of order");

    a_qn_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_qn) <= ALPHABET)
        else $error("merge queue count overflow");

    a_pop_then_ins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |=> (r_state == S_INS))
        else $error("pop not followed by insert");

    a_none_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tlast && o_m_tdata[34:30] == '0))
        else $error("empty table result malformed");

endmodule
